// ===== sv/okvm_pkg.sv =====
// Shared constants, codes and types of the organ key voice manager.
`timescale 1ns / 1ps

package okvm_pkg;

    // Sizes
    localparam int MAX_ITEMS = 64;
    localparam int COUNT_W   = 8;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int ITEM_W    = 7;
    localparam int AGE_W     = 7;
    localparam int MODE_W    = 2;
    localparam int CIDX_W    = 2;
    localparam int LIM_W     = ($clog2(MAX_ITEMS + 1) > ITEM_W) ? $clog2(MAX_ITEMS + 1) : ITEM_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [AGE_W-1:0]   AGE_MAX   = '1;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_REQ   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SENSE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_ITEMS = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_POLY  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_KEYS  = 2'd2;

    // Reset values of the configuration registers
    localparam logic [ITEM_W-1:0] RST_ITEMS = 7'd61;
    localparam logic [ITEM_W-1:0] RST_POLY  = 7'd10;
    localparam logic              RST_KEYS  = 1'b1;

    // One stored key entry
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [AGE_W-1:0]   age;
        logic               user;
        logic               active;
    } t_entry;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ITEM_W-1:0] item_number;
        logic              turn_on;
    } t_item;

    typedef struct packed {
        logic              we;
        logic [CIDX_W-1:0] index;
        logic [ITEM_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic               error;
        logic               toggle_valid;
        logic               toggle_on;
        logic               steal_valid;
        logic [ITEM_W-1:0]  steal_item;
        logic [COUNT_W-1:0] request_count;
        logic [AGE_W-1:0]   system_age;
        logic               user_flag;
        logic               active_flag;
    } t_result;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic eval;
        logic walk_rd;
        logic fin;
        logic load_out;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_range;
        logic walk_need;
        logic press_now;
        logic press;
        logic walk_last;
    } t_dp_sts;

endpackage

// ===== sv/okvm_if.sv =====
// Channel interfaces: input items, result items and configuration writes.
`timescale 1ns / 1ps

interface okvm_in_if import okvm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [ITEM_W-1:0] item_number;
    logic              turn_on;

    modport source (output valid, output mode, output item_number, output turn_on,
                    input ready);
    modport sink   (input valid, input mode, input item_number, input turn_on,
                    output ready);
endinterface

interface okvm_out_if import okvm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               error;
    logic               toggle_valid;
    logic               toggle_on;
    logic               steal_valid;
    logic [ITEM_W-1:0]  steal_item;
    logic [COUNT_W-1:0] request_count;
    logic [AGE_W-1:0]   system_age;
    logic               user_flag;
    logic               active_flag;

    modport source (output valid, output error, output toggle_valid, output toggle_on,
                    output steal_valid, output steal_item, output request_count,
                    output system_age, output user_flag, output active_flag,
                    input ready);
    modport sink   (input valid, input error, input toggle_valid, input toggle_on,
                    input steal_valid, input steal_item, input request_count,
                    input system_age, input user_flag, input active_flag,
                    output ready);
endinterface

interface okvm_cfg_if import okvm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CIDX_W-1:0] index;
    logic [ITEM_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/okvm_ctrl.sv =====
// Controller state machine: sequences read, update, age walk and result beat.
`timescale 1ns / 1ps

module okvm_ctrl import okvm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_ov, n_ov;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_ov    = r_ov;
        o_cmd   = '0;
        if (r_ov && i_out_ready) begin
            n_ov = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_READ;
                end
            end
            // entry read is issued here; out-of-range items skip straight to the result
            S_READ: begin
                n_state = i_sts.in_range ? S_EVAL : S_DONE;
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                priority if (i_sts.walk_need) begin
                    n_state = S_WALK;
                end else if (i_sts.press_now) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_WALK: begin
                o_cmd.walk_rd = 1'b1;
                if (i_sts.walk_last) begin
                    n_state = S_DRAIN;
                end
            end
            // last walk write-back lands here
            S_DRAIN: begin
                n_state = i_sts.press ? S_FIN : S_DONE;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_ov || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_ov           = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ov;

endmodule

// ===== sv/okvm_dpath.sv =====
// Datapath: configuration registers, key entry memory, update and age walk logic.
`timescale 1ns / 1ps

module okvm_dpath import okvm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg_wr,
    input  t_item   i_item,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts,
    output t_result o_res
);

    // Configuration
    logic [ITEM_W-1:0] r_items;
    logic [ITEM_W-1:0] r_poly;
    logic              r_keys;

    // Captured item
    logic [MODE_W-1:0] r_mode;
    logic [ITEM_W-1:0] r_num;
    logic              r_on;

    // Entry memory with per-entry valid bits (invalid reads as zero)
    t_entry             r_mem [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] r_vld;
    t_entry             r_rd_data;
    logic               r_rd_vld;
    t_entry             rd_e;

    // Step state
    t_entry            r_cur;
    logic [AGE_W-1:0]  r_old_age;
    logic              r_tog;
    logic              r_ton;
    logic              r_steal;
    logic [ITEM_W-1:0] r_steal_item;
    t_result           r_res;

    // Walk pipeline
    logic [IDX_W-1:0]  r_wk_cnt;
    logic [IDX_W-1:0]  r_wk_addr;
    logic              r_wk_pend;

    logic [LIM_W-1:0]  limit;
    logic [LIM_W-1:0]  items_ext;
    logic [LIM_W-1:0]  num_ext;
    logic              in_range;
    logic [IDX_W-1:0]  idx;
    t_entry            e;
    logic              e_tog;
    logic              e_ton;
    t_entry            w;
    logic              w_stl;
    t_entry            fin_e;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    t_entry            wr_data;
    logic [IDX_W-1:0]  rd_addr;
    logic [LIM_W-1:0]  steal_num;

    // Range check against the clamped key count
    always_comb begin
        items_ext = LIM_W'(r_items);
        limit     = (items_ext < LIM_W'(MAX_ITEMS)) ? items_ext : LIM_W'(MAX_ITEMS);
        num_ext   = LIM_W'(r_num);
        in_range  = (num_ext != '0) && (num_ext <= limit);
        idx       = IDX_W'(num_ext - LIM_W'(1));
    end

    assign rd_e = r_rd_vld ? r_rd_data : '0;

    // Item update of the addressed entry
    always_comb begin
        e     = rd_e;
        e_tog = 1'b0;
        e_ton = 1'b0;
        unique case (r_mode)
            MODE_REQ: begin
                if (!r_on) begin
                    if (e.count != '0) begin
                        e.count = e.count - COUNT_W'(1);
                        if (e.count == '0) begin
                            e_tog = 1'b1;
                        end
                    end
                end else if (e.count != COUNT_MAX) begin
                    e.count = e.count + COUNT_W'(1);
                    if (e.count == COUNT_W'(1)) begin
                        e_tog = 1'b1;
                        e_ton = 1'b1;
                    end
                end
                // toggled key leaves the age order for now
                if (e_tog) begin
                    e.age    = '0;
                    e.active = e.active & e.user;
                end
            end
            MODE_SENSE: begin
                if (e.age == '0) begin
                    e.user   = r_on;
                    e.active = r_on;
                end else begin
                    e.user   = 1'b0;
                    e.active = 1'b1;
                end
            end
            default: begin
                e = rd_e;
            end
        endcase
    end

    // Age walk step on one entry
    always_comb begin
        w     = rd_e;
        w_stl = 1'b0;
        if (w.age != '0) begin
            if (r_ton) begin
                if (w.age != AGE_MAX) begin
                    w.age = w.age + AGE_W'(1);
                end
                w.user   = 1'b0;
                w.active = 1'b1;
            end else if (w.age > r_old_age) begin
                w.age = w.age - AGE_W'(1);
                if (w.age == '0) begin
                    w.active = w.active & w.user;
                end else begin
                    w.user   = 1'b0;
                    w.active = 1'b1;
                end
            end
        end
        // past the polyphony limit: steal
        if (w.age > r_poly) begin
            w.age    = '0;
            w.count  = '0;
            w.active = w.active & w.user;
            w_stl    = 1'b1;
        end
    end

    // Pressed key becomes the newest
    always_comb begin
        fin_e        = r_cur;
        fin_e.age    = AGE_W'(1);
        fin_e.user   = 1'b0;
        fin_e.active = 1'b1;
    end

    // Memory port selection
    always_comb begin
        rd_addr = i_cmd.walk_rd ? r_wk_cnt : idx;
        wr_en   = i_cmd.eval | r_wk_pend | i_cmd.fin;
        priority if (r_wk_pend) begin
            wr_addr = r_wk_addr;
            wr_data = w;
        end else if (i_cmd.fin) begin
            wr_addr = idx;
            wr_data = fin_e;
        end else begin
            wr_addr = idx;
            wr_data = e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
        r_rd_vld  <= r_vld[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[wr_addr] <= 1'b1;
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_items <= RST_ITEMS;
            r_poly  <= RST_POLY;
            r_keys  <= RST_KEYS;
        end else if (i_cfg_wr.we) begin
            unique case (i_cfg_wr.index)
                CFG_ITEMS: r_items <= i_cfg_wr.data;
                CFG_POLY:  r_poly  <= i_cfg_wr.data;
                CFG_KEYS:  r_keys  <= i_cfg_wr.data[0];
                default:   r_items <= r_items;
            endcase
        end
    end

    // Item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_item.mode;
            r_num  <= i_item.item_number;
            r_on   <= i_item.turn_on;
        end
    end

    // Walk counter and write-back pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wk_pend <= 1'b0;
        end else begin
            r_wk_pend <= i_cmd.walk_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wk_addr <= r_wk_cnt;
        if (i_cmd.eval) begin
            r_wk_cnt <= '0;
        end else if (i_cmd.walk_rd) begin
            r_wk_cnt <= r_wk_cnt + IDX_W'(1);
        end
    end

    assign steal_num = LIM_W'(r_wk_addr) + LIM_W'(1);

    // Step state: toggle, steal, addressed entry
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_tog        <= 1'b0;
            r_ton        <= 1'b0;
            r_steal      <= 1'b0;
            r_steal_item <= '0;
        end else begin
            if (i_cmd.eval) begin
                r_tog     <= e_tog;
                r_ton     <= e_ton;
                r_old_age <= rd_e.age;
                r_cur     <= e;
            end
            if (i_cmd.fin) begin
                r_cur <= fin_e;
            end
            // lowest stolen key wins, the walk runs upward
            if (r_wk_pend && w_stl && !r_steal) begin
                r_steal      <= 1'b1;
                r_steal_item <= ITEM_W'(steal_num);
            end
        end
    end

    // Result register; an out-of-range item reports only the error flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_res.error         <= !in_range;
            r_res.toggle_valid  <= in_range & r_tog;
            r_res.toggle_on     <= in_range & r_ton;
            r_res.steal_valid   <= in_range & r_steal;
            r_res.steal_item    <= in_range ? r_steal_item : '0;
            r_res.request_count <= in_range ? r_cur.count : '0;
            r_res.system_age    <= in_range ? r_cur.age : '0;
            r_res.user_flag     <= in_range & r_cur.user;
            r_res.active_flag   <= in_range & r_cur.active;
        end
    end

    assign o_res = r_res;

    always_comb begin
        o_sts.in_range  = in_range;
        o_sts.walk_need = e_tog & r_keys;
        o_sts.press_now = e_tog & e_ton;
        o_sts.press     = r_tog & r_ton;
        o_sts.walk_last = (LIM_W'(r_wk_cnt) == (limit - LIM_W'(1)));
    end

endmodule

// ===== sv/organ_key_voice_manager_unit.sv =====
// Top level of the organ key voice manager: channels, controller and datapath.
//
//  channel  | dir | beat payload                                     | handshake
//  ---------+-----+--------------------------------------------------+------------
//  i_in     | in  | mode, item_number, turn_on                       | valid/ready
//  o_out    | out | error, toggle, steal, count, age, user, active   | valid/ready
//  i_cfg    | in  | index (0 items, 1 polyphony, 2 keys mode), data  | valid/ready
//
//  One item at a time. An out-of-range item goes straight to the result; any other item
//  is read and updated, and a press in stops mode then also writes the new key. A toggle in
//  keys mode walks the managed entries, min(items_in_use, 64) of them, one per cycle, and a
//  press then writes the new key. The next beat is taken the cycle after the result loads.
//  Reset is synchronous, active low; it clears all key state and loads register defaults.
//  A held result stalls only the end of the next item; configuration beats are always taken.
`timescale 1ns / 1ps

module organ_key_voice_manager_unit import okvm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    okvm_in_if.sink     i_in,
    okvm_cfg_if.sink    i_cfg,
    okvm_out_if.source  o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    t_result res;
    t_item   item;
    t_cfg_wr cfg_wr;
    logic    in_ready;
    logic    out_valid;

    // Channel payloads into structs
    always_comb begin
        item.mode        = i_in.mode;
        item.item_number = i_in.item_number;
        item.turn_on     = i_in.turn_on;
        cfg_wr.we        = i_cfg.valid;
        cfg_wr.index     = i_cfg.index;
        cfg_wr.data      = i_cfg.data;
    end

    okvm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    okvm_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_wr (cfg_wr),
        .i_item   (item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_res    (res)
    );

    // Result channel
    assign i_in.ready          = in_ready;
    assign i_cfg.ready         = 1'b1;
    assign o_out.valid         = out_valid;
    assign o_out.error         = res.error;
    assign o_out.toggle_valid  = res.toggle_valid;
    assign o_out.toggle_on     = res.toggle_on;
    assign o_out.steal_valid   = res.steal_valid;
    assign o_out.steal_item    = res.steal_item;
    assign o_out.request_count = res.request_count;
    assign o_out.system_age    = res.system_age;
    assign o_out.user_flag     = res.user_flag;
    assign o_out.active_flag   = res.active_flag;

endmodule

// ===== sv/okvm_chk.sv =====
// Port checker for the organ key voice manager, bound to the top level.
`timescale 1ns / 1ps

module okvm_chk import okvm_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_error,
    input logic               i_toggle_valid,
    input logic               i_toggle_on,
    input logic               i_steal_valid,
    input logic [ITEM_W-1:0]  i_steal_item,
    input logic [COUNT_W-1:0] i_request_count,
    input logic [AGE_W-1:0]   i_system_age,
    input logic               i_user_flag,
    input logic               i_active_flag
);

    // One item in flight: an accepted beat closes the input for the next cycle
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted back to back");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_steal_item)
            && $stable(i_request_count) && $stable(i_system_age) && $stable(i_error))
        else $error("stalled result changed");

    // Error results carry nothing else
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_error |-> !i_toggle_valid && !i_toggle_on && !i_steal_valid
            && i_steal_item == '0 && i_request_count == '0 && i_system_age == '0
            && !i_user_flag && !i_active_flag)
        else $error("error result with state fields");

    // Steal flag and stolen key number agree
    a_steal_num: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_steal_valid == (i_steal_item != '0))
        else $error("steal flag and number disagree");

    // A key turned on is the newest, active, system held, one request
    a_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_toggle_valid && i_toggle_on |-> i_system_age == AGE_W'(1)
            && i_active_flag && !i_user_flag && i_request_count == COUNT_W'(1))
        else $error("pressed key state wrong");

endmodule

bind organ_key_voice_manager_unit okvm_chk u_okvm_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_error         (o_out.error),
    .i_toggle_valid  (o_out.toggle_valid),
    .i_toggle_on     (o_out.toggle_on),
    .i_steal_valid   (o_out.steal_valid),
    .i_steal_item    (o_out.steal_item),
    .i_request_count (o_out.request_count),
    .i_system_age    (o_out.system_age),
    .i_user_flag     (o_out.user_flag),
    .i_active_flag   (o_out.active_flag)
);
